[rtl/spimbe_pkg.sv]
// ----------------------------------------------------------------------------
// spimbe_pkg: shared definitions for the SPI master bit engine
// Phase codes, register indexes, reset values and the request/result records.
// ----------------------------------------------------------------------------
package spimbe_pkg;

   localparam int unsigned CNT_W         = 16;
   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_SETUP = 3'd1;
   localparam logic [2:0] PH_LOW   = 3'd2;
   localparam logic [2:0] PH_HIGH  = 3'd3;
   localparam logic [2:0] PH_AWAIT = 3'd4;
   localparam logic [2:0] PH_HOLD  = 3'd5;

   localparam logic REG_CS_DELAY = 1'b0;
   localparam logic REG_HALF_BIT = 1'b1;

   localparam logic [CNT_W-1:0] CS_DELAY_RESET = 16'd500;
   localparam logic [CNT_W-1:0] HALF_BIT_RESET = 16'd100;

   typedef struct packed {
      logic       tick;
      logic       cmd_valid;
      logic       func;
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       miso;
   } req_type;

   typedef struct packed {
      logic       cs_n;
      logic       sck;
      logic       mosi;
      logic       cmd_ready;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } rsp_type;

endpackage

[rtl/spimbe_seq.sv]
// ----------------------------------------------------------------------------
// spimbe_seq: pin sequencer of the SPI master bit engine
// Holds phase, tick counter, shifter, pin levels and the timing registers;
// computes the result of one request and advances on accept.
// ----------------------------------------------------------------------------
module spimbe_seq
   import spimbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CNT_W-1:0] csr_wdata,
   input  logic             step_en,
   input  req_type          req,
   output rsp_type          rsp
);

   logic [2:0]           phase_ff, phase_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in, bit_inc;
   logic [7:0]           shift_ff, shift_in;
   logic                 recv_ff, recv_in;
   logic                 end_ff, end_in;
   logic                 cs_ff, cs_in, sck_ff, sck_in, mosi_ff, mosi_in;
   logic [CNT_W-1:0]     cs_delay_ff, half_bit_ff, limit;
   logic [CNT_W:0]       count_inc;
   logic                 done;

   // one counter serves every delay; a limit of zero behaves like one
   always_comb begin
      limit     = (phase_ff == PH_LOW || phase_ff == PH_HIGH) ? half_bit_ff : cs_delay_ff;
      count_inc = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};
      done      = req.tick && (count_inc >= {1'b0, limit});
      bit_inc   = bit_ff + BIT_IDX_W'(1);
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      recv_in  = recv_ff;
      end_in   = end_ff;
      cs_in    = cs_ff;
      sck_in   = sck_ff;
      mosi_in  = mosi_ff;
      rsp      = '0;
      if (req.tick) begin
         count_in = done ? '0 : count_inc[CNT_W-1:0];
      end
      unique case (phase_ff)
         PH_SETUP: begin
            if (done) begin
               sck_in   = 1'b0;
               mosi_in  = recv_ff ? mosi_ff : shift_ff[bit_ff];
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            if (done) begin
               if (recv_ff && req.miso) begin
                  shift_in[bit_ff] = 1'b1;
               end
               sck_in   = 1'b1;
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            if (done) begin
               if (bit_ff == LAST_BIT) begin
                  bit_in       = '0;
                  rsp.rx_valid = recv_ff;
                  rsp.rx_byte  = recv_ff ? shift_ff : 8'd0;
                  phase_in     = end_ff ? PH_HOLD : PH_AWAIT;
               end else begin
                  bit_in   = bit_inc;
                  sck_in   = 1'b0;
                  mosi_in  = recv_ff ? mosi_ff : shift_ff[bit_inc];
                  phase_in = PH_LOW;
               end
            end
         end
         PH_AWAIT: begin
            // next byte of an open frame starts its low half at once
            count_in = count_ff;
            if (req.cmd_valid) begin
               rsp.cmd_ready = 1'b1;
               recv_in  = req.func;
               end_in   = req.last_byte;
               shift_in = req.func ? 8'd0 : req.tx_byte;
               bit_in   = '0;
               count_in = '0;
               sck_in   = 1'b0;
               mosi_in  = req.func ? mosi_ff : req.tx_byte[0];
               phase_in = PH_LOW;
            end
         end
         PH_HOLD: begin
            if (done) begin
               cs_in    = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            count_in = count_ff;
            phase_in = PH_IDLE;
            if (req.cmd_valid) begin
               rsp.cmd_ready = 1'b1;
               recv_in  = req.func;
               end_in   = req.last_byte;
               shift_in = req.func ? 8'd0 : req.tx_byte;
               bit_in   = '0;
               count_in = '0;
               cs_in    = 1'b0;
               if (req.func) begin
                  sck_in = 1'b0;
               end
               phase_in = PH_SETUP;
            end
         end
      endcase
      rsp.cs_n = cs_in;
      rsp.sck  = sck_in;
      rsp.mosi = mosi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         recv_ff  <= 1'b0;
         end_ff   <= 1'b0;
         cs_ff    <= 1'b1;
         sck_ff   <= 1'b1;
         mosi_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         recv_ff  <= recv_in;
         end_ff   <= end_in;
         cs_ff    <= cs_in;
         sck_ff   <= sck_in;
         mosi_ff  <= mosi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_delay_ff <= CS_DELAY_RESET;
         half_bit_ff <= HALF_BIT_RESET;
      end else if (csr_we) begin
         if (csr_addr == REG_CS_DELAY) begin
            cs_delay_ff <= csr_wdata;
         end
         if (csr_addr == REG_HALF_BIT) begin
            half_bit_ff <= csr_wdata;
         end
      end
   end

   a_cs_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> cs_ff)
      else $error("chip select low while idle");

   a_ready_phase: assert property (@(posedge clock) disable iff (reset)
      rsp.cmd_ready |-> (phase_ff == PH_IDLE || phase_ff == PH_AWAIT))
      else $error("command taken in the middle of a byte");

   a_rx_recv: assert property (@(posedge clock) disable iff (reset)
      rsp.rx_valid |-> (recv_ff && phase_ff == PH_HIGH && bit_ff == LAST_BIT))
      else $error("receive byte flagged outside a receive byte end");

   a_bit_idx: assert property (@(posedge clock) disable iff (reset)
      (bit_ff != '0) |-> (phase_ff == PH_LOW || phase_ff == PH_HIGH))
      else $error("bit index left nonzero outside a byte");

endmodule

[rtl/spi_master_bit_engine_core.sv]
// ----------------------------------------------------------------------------
// spi_master_bit_engine_core: SPI master bit engine, LSB first
// The result is registered: it is valid in the output register in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken, set by the single-pass sequencer step.
// The output register frees in the cycle it is taken, so requests keep flowing.
// Reset: synchronous; idle phase, chip select and clock high, mosi low,
// timing registers back to 500 and 100 ticks, output register empty.
// ----------------------------------------------------------------------------
module spi_master_bit_engine_core
   import spimbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tick, cmd_valid, tx_byte[7:0], miso, zero pad
   input  logic [0:0]  req_tuser,   // func
   input  logic        req_tlast,   // last_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cs_n, sck, mosi, cmd_ready, rx_valid, rx_byte[7:0], pad
   // register writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   req_type req;
   rsp_type step_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    accept;

   // take a request whenever the output register is empty or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // unpack the request fields
   always_comb begin
      req.tick      = req_tdata[0];
      req.cmd_valid = req_tdata[1];
      req.tx_byte   = req_tdata[9:2];
      req.miso      = req_tdata[10];
      req.func      = req_tuser[0];
      req.last_byte = req_tlast;
   end

   spimbe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .step_en   (accept),
      .req       (req),
      .rsp       (step_rsp)
   );

   // hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.rx_byte, rsp_ff.rx_valid, rsp_ff.cmd_ready,
                        rsp_ff.mosi, rsp_ff.sck, rsp_ff.cs_n};

endmodule

[test/spimbe_checker.sv]
// ----------------------------------------------------------------------------
// spimbe_checker: scoreboard for the SPI master bit engine
// Tracks register writes, predicts the pin levels and received bytes for each
// accepted request, and compares every result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spimbe_checker
   import spimbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // tick, cmd_valid, tx_byte[7:0], miso, zero pad
   input  logic [0:0]  req_tuser,   // func
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // cs_n, sck, mosi, cmd_ready, rx_valid, rx_byte[7:0], pad
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam int REPORT_MAX = 10;

   logic [CNT_W-1:0]     cs_delay;
   logic [CNT_W-1:0]     half_bit;
   logic [2:0]           seq_phase;
   logic [CNT_W-1:0]     tick_cnt;
   logic [BIT_IDX_W-1:0] bit_pos;
   logic [7:0]           shreg;
   logic                 rx_mode;
   logic                 frame_end;
   logic                 pin_cs_n;
   logic                 pin_sck;
   logic                 pin_mosi;
   rsp_type              pin_q[$];

   // Count one tick against a limit; a limit of zero behaves like one.
   function automatic logic delay_done(logic tk, logic [CNT_W-1:0] lim);
      if (!tk)
         return 1'b0;
      if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, lim}) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 1'b1;
      return 1'b0;
   endfunction

   function automatic void start_low();
      pin_sck = 1'b0;
      if (!rx_mode)
         pin_mosi = shreg[bit_pos];
      tick_cnt  = '0;
      seq_phase = PH_LOW;
   endfunction

   function automatic void load_byte(req_type r);
      rx_mode   = r.func;
      frame_end = r.last_byte;
      shreg     = r.func ? 8'h00 : r.tx_byte;
      bit_pos   = '0;
      tick_cnt  = '0;
   endfunction

   function automatic rsp_type spi_step(req_type r);
      rsp_type o;
      o = '0;
      case (seq_phase)
         PH_SETUP: if (delay_done(r.tick, cs_delay))
            start_low();
         PH_LOW: if (delay_done(r.tick, half_bit)) begin
            if (rx_mode && r.miso)
               shreg[bit_pos] = 1'b1;
            pin_sck   = 1'b1;
            seq_phase = PH_HIGH;
         end
         PH_HIGH: if (delay_done(r.tick, half_bit)) begin
            if (bit_pos == LAST_BIT) begin
               bit_pos = '0;
               if (rx_mode) begin
                  o.rx_valid = 1'b1;
                  o.rx_byte  = shreg;
               end
               seq_phase = frame_end ? PH_HOLD : PH_AWAIT;
            end else begin
               bit_pos = bit_pos + 1'b1;
               start_low();
            end
         end
         PH_AWAIT: if (r.cmd_valid) begin
            o.cmd_ready = 1'b1;
            load_byte(r);
            start_low();
         end
         PH_HOLD: if (delay_done(r.tick, cs_delay)) begin
            pin_cs_n  = 1'b1;
            seq_phase = PH_IDLE;
         end
         default: begin
            seq_phase = PH_IDLE;
            if (r.cmd_valid) begin
               o.cmd_ready = 1'b1;
               load_byte(r);
               pin_cs_n = 1'b0;
               if (rx_mode)
                  pin_sck = 1'b0;
               seq_phase = PH_SETUP;
            end
         end
      endcase
      o.cs_n = pin_cs_n;
      o.sck  = pin_sck;
      o.mosi = pin_mosi;
      return o;
   endfunction

   always @(posedge clock) begin
      req_type req;
      rsp_type got;
      rsp_type want;
      if (reset) begin
         cs_delay   = CS_DELAY_RESET;
         half_bit   = HALF_BIT_RESET;
         seq_phase  = PH_IDLE;
         tick_cnt   = '0;
         bit_pos    = '0;
         shreg      = '0;
         rx_mode    = 1'b0;
         frame_end  = 1'b0;
         pin_cs_n   = 1'b1;
         pin_sck    = 1'b1;
         pin_mosi   = 1'b0;
         fail_count = 0;
         pin_q.delete();
      end else begin
         // Check the result first: a request taken at this edge cannot have
         // produced it yet.
         if (rsp_tvalid && rsp_tready) begin
            got.cs_n      = rsp_tdata[0];
            got.sck       = rsp_tdata[1];
            got.mosi      = rsp_tdata[2];
            got.cmd_ready = rsp_tdata[3];
            got.rx_valid  = rsp_tdata[4];
            got.rx_byte   = rsp_tdata[12:5];
            if (pin_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: result with no request pending: %h", $time, rsp_tdata);
            end else begin
               want = pin_q.pop_front();
               if (got.cs_n !== want.cs_n || got.sck !== want.sck || got.mosi !== want.mosi
                   || got.cmd_ready !== want.cmd_ready || got.rx_valid !== want.rx_valid
                   || got.rx_byte !== want.rx_byte) begin
                  fail_count++;
                  // fields: cs_n sck mosi, cmd_ready, rx_valid, rx_byte
                  if (fail_count <= REPORT_MAX)
                     $display("%0t: mismatch expected %b%b%b %b %b %h got %b%b%b %b %b %h",
                              $time, want.cs_n, want.sck, want.mosi, want.cmd_ready,
                              want.rx_valid, want.rx_byte, got.cs_n, got.sck, got.mosi,
                              got.cmd_ready, got.rx_valid, got.rx_byte);
               end
            end
         end
         // A request taken at this edge still sees the old register values.
         if (req_tvalid && req_tready) begin
            req.tick      = req_tdata[0];
            req.cmd_valid = req_tdata[1];
            req.tx_byte   = req_tdata[9:2];
            req.miso      = req_tdata[10];
            req.func      = req_tuser[0];
            req.last_byte = req_tlast;
            pin_q.push_back(spi_step(req));
         end
         if (csr_we) begin
            if (csr_addr == REG_CS_DELAY)
               cs_delay = csr_wdata;
            else
               half_bit = csr_wdata;
         end
      end
      pending_count = pin_q.size();
   end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the SPI master bit engine core
// Drives tick/command requests with random gaps and back-pressure, steps the
// timing registers through several settings, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import spimbe_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_SETTINGS    = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic        csr_addr;
   logic [15:0] csr_wdata;

   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   bit src_idle_on;
   bit snk_idle_on;
   bit hold_off_req;

   spi_master_bit_engine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   spimbe_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Watchdog: count cycles in which neither channel moves a request or result.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: accept with random stalls; on request hold off for a long
   // stretch so the output register fills and the request side stalls.
   initial begin : result_sink
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one request, optionally after a gap, and hold it until accepted.
   // Call and return at a falling edge.
   task automatic send_request(input logic tk, input logic cmd, input logic fn,
                               input logic [7:0] data, input logic last, input logic mi);
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, mi, data, cmd, tk};
      req_tuser  <= fn;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      send_request($urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0,
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_timing(input logic [15:0] cs, input logic [15:0] half);
      csr_we    <= 1'b1;
      csr_addr  <= REG_CS_DELAY;
      csr_wdata <= cs;
      @(negedge clock);
      csr_addr  <= REG_HALF_BIT;
      csr_wdata <= half;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned cs_set[NUM_SETTINGS];
      int unsigned half_set[NUM_SETTINGS];
      int          item_cnt[NUM_SETTINGS];
      cs_set   = '{1, 2, 1, 3, 65535, 0, 4, 1};
      half_set = '{1, 1, 3, 2, 65535, 1, 2, 1};
      item_cnt = '{250, 250, 250, 250, 60, 250, 250, 250};
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      req_tlast    = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = REG_CS_DELAY;
      csr_wdata    = '0;
      src_idle_on  = 1'b0;
      snk_idle_on  = 1'b0;
      hold_off_req = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset timing, an all-zero and an all-ones request (opens a
      // receive frame, clock drops), then a command while busy.
      send_request(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      send_request(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1);
      send_request(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
      drain();
      // Zero delays act like one tick: finish the receive byte and its hold.
      set_timing(16'd0, 16'd0);
      for (int i = 0; i < 18; i++)
         send_request(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, i[0]);
      // Open a transmit frame on a cycle without a tick.
      send_request(1'b0, 1'b1, 1'b0, 8'hA5, 1'b0, 1'b0);

      // Random phases, one timing setting each.
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         drain();
         if (p == 6)
            set_timing(16'($urandom_range(1, 8)), 16'($urandom_range(1, 4)));
         else
            set_timing(16'(cs_set[p]), 16'(half_set[p]));
         // Run a couple of phases with no idling at all.
         src_idle_on = (p != 1) && (p != 5);
         snk_idle_on = (p != 1) && (p != 5) && (p != 3);
         for (int n = 0; n < item_cnt[p]; n++) begin
            if (p == 0 && n == 100)
               hold_off_req = 1'b1;
            if (p == 2 && n == 125)
               drain();
            send_random();
         end
      end

      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
